[sv/wasm_integer_alu_top_assert.svh]
// Assertion macros for the integer ALU top level.
`ifndef WASM_INTEGER_ALU_TOP_ASSERT_SVH
`define WASM_INTEGER_ALU_TOP_ASSERT_SVH
// implication checked on every clock edge outside reset
`define ALU_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("alu check failed");
// next-cycle implication
`define ALU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("alu check failed");
`endif

[sv/wai_pkg.sv]
// Package for the integer ALU: operation codes, sizes, cell payload type.
`default_nettype none
package wai_pkg;
   localparam int unsigned XLEN = 64;
   localparam int unsigned NUM_CELLS_DEF = 64;

   typedef enum logic [4:0] {
      OP_EQZ64 = 5'd0, OP_CLZ64 = 5'd1, OP_CTZ64 = 5'd2, OP_POP64 = 5'd3,
      OP_CLZ32 = 5'd4, OP_CTZ32 = 5'd5, OP_POP32 = 5'd6,
      OP_EQ = 5'd7, OP_NE = 5'd8, OP_LTS = 5'd9, OP_LTU = 5'd10,
      OP_GTS = 5'd11, OP_GTU = 5'd12, OP_LES = 5'd13, OP_LEU = 5'd14,
      OP_GES = 5'd15, OP_GEU = 5'd16,
      OP_ROTL32 = 5'd17, OP_ROTR32 = 5'd18, OP_ROTL64 = 5'd19, OP_ROTR64 = 5'd20,
      OP_MUL = 5'd21, OP_DIVS = 5'd22, OP_DIVU = 5'd23, OP_REMS = 5'd24,
      OP_REMU = 5'd25, OP_SHL = 5'd26, OP_SHRS = 5'd27, OP_SHRU = 5'd28
   } op_type;

   localparam logic [1:0] TRAP_NONE = 2'd0;
   localparam logic [1:0] TRAP_DIV0 = 2'd1;
   localparam logic [1:0] TRAP_OVF  = 2'd2;

   // payload carried from cell to cell of the divider chain
   typedef struct packed {
      logic             valid;
      logic             is_div;
      logic             is_mul;
      logic [XLEN-1:0]  quo;    // dividend (or multiplier) shifting out, quotient shifting in
      logic [XLEN-1:0]  rem;    // partial remainder, or product accumulator
      logic [XLEN-1:0]  dvs;    // divisor magnitude, or multiplicand
      logic             neg_q;
      logic             neg_r;
      logic             want_rem;
      logic [XLEN-1:0]  res;    // result of non-divide operations
      logic [1:0]       trap;
   } cell_type;
endpackage
`default_nettype wire

[sv/wai_cell.sv]
// One chain cell: retires one quotient bit or one multiplier bit per cycle while advance is high.
`default_nettype none
module wai_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wai_pkg::cell_type      cell_in,
   output wai_pkg::cell_type      cell_out
);
   wai_pkg::cell_type cell_ff;
   wai_pkg::cell_type cell_in_c;
   logic [wai_pkg::XLEN:0] trial;
   logic [wai_pkg::XLEN:0] shifted;

   always_comb begin
      cell_in_c = cell_in;
      shifted = {cell_in.rem, cell_in.quo[wai_pkg::XLEN-1]};
      trial = shifted - {1'b0, cell_in.dvs};
      if (cell_in.is_div) begin
         if (!trial[wai_pkg::XLEN]) begin
            cell_in_c.rem = trial[wai_pkg::XLEN-1:0];
         end else begin
            cell_in_c.rem = shifted[wai_pkg::XLEN-1:0];
         end
         cell_in_c.quo = {cell_in.quo[wai_pkg::XLEN-2:0], ~trial[wai_pkg::XLEN]};
      end else if (cell_in.is_mul) begin
         // shift-and-add, multiplier msb first
         cell_in_c.rem = {cell_in.rem[wai_pkg::XLEN-2:0], 1'b0}
                         + (cell_in.quo[wai_pkg::XLEN-1] ? cell_in.dvs : '0);
         cell_in_c.quo = {cell_in.quo[wai_pkg::XLEN-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff <= cell_in_c;
      end
   end

   assign cell_out = cell_ff;
endmodule
`default_nettype wire

[sv/wai_front.sv]
// Entry stage: non-divide operations, multiplier setup and divider setup.
`default_nettype none
module wai_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              in_valid,
   input  wire logic [4:0]        action,
   input  wire logic [63:0]       operand_a,
   input  wire logic [63:0]       operand_b,
   output wai_pkg::cell_type      cell_out
);
   wai_pkg::cell_type front_ff;
   wai_pkg::cell_type front_in;
   logic [63:0] a32;
   logic [63:0] ma;
   logic [63:0] mb;
   logic        an;
   logic        bn;
   logic        lts;
   logic        ltu;
   logic [5:0]  s6;
   logic [4:0]  s5;
   logic [6:0]  clz64;
   logic [6:0]  ctz64;
   logic [6:0]  pop64;
   logic [6:0]  pop32;
   logic [5:0]  clz32;
   logic [5:0]  ctz32;
   logic [63:0] rot64l;
   logic [63:0] rot64r;
   logic [31:0] rot32l;
   logic [31:0] rot32r;

   always_comb begin
      a32 = {32'd0, operand_a[31:0]};
      an = operand_a[63];
      bn = operand_b[63];
      ma = an ? (~operand_a + 64'd1) : operand_a;
      mb = bn ? (~operand_b + 64'd1) : operand_b;
      ltu = operand_a < operand_b;
      lts = $signed(operand_a) < $signed(operand_b);
      s6 = operand_b[5:0];
      s5 = operand_b[4:0];
      clz64 = 7'd64;
      for (int i = 0; i < 64; i++) begin
         if (operand_a[i]) clz64 = 7'(63 - i);
      end
      ctz64 = 7'd64;
      for (int i = 63; i >= 0; i--) begin
         if (operand_a[i]) ctz64 = 7'(i);
      end
      clz32 = 6'd32;
      for (int i = 0; i < 32; i++) begin
         if (operand_a[i]) clz32 = 6'(31 - i);
      end
      ctz32 = 6'd32;
      for (int i = 31; i >= 0; i--) begin
         if (operand_a[i]) ctz32 = 6'(i);
      end
      pop64 = 7'($countones(operand_a));
      pop32 = 7'($countones(operand_a[31:0]));
      rot64l = (operand_a << s6) | (operand_a >> (7'd64 - {1'b0, s6}));
      rot64r = (operand_a >> s6) | (operand_a << (7'd64 - {1'b0, s6}));
      rot32l = (operand_a[31:0] << s5) | (operand_a[31:0] >> (6'd32 - {1'b0, s5}));
      rot32r = (operand_a[31:0] >> s5) | (operand_a[31:0] << (6'd32 - {1'b0, s5}));

      front_in = '0;
      front_in.valid = in_valid;
      front_in.dvs = mb;
      front_in.quo = ma;
      front_in.trap = wai_pkg::TRAP_NONE;
      case (action) inside
         wai_pkg::OP_EQZ64:  front_in.res = {63'd0, operand_a == 64'd0};
         wai_pkg::OP_CLZ64:  front_in.res = {57'd0, clz64};
         wai_pkg::OP_CTZ64:  front_in.res = {57'd0, ctz64};
         wai_pkg::OP_POP64:  front_in.res = {57'd0, pop64};
         wai_pkg::OP_CLZ32:  front_in.res = {58'd0, clz32};
         wai_pkg::OP_CTZ32:  front_in.res = {58'd0, ctz32};
         wai_pkg::OP_POP32:  front_in.res = {57'd0, pop32};
         wai_pkg::OP_EQ:     front_in.res = {63'd0, operand_a == operand_b};
         wai_pkg::OP_NE:     front_in.res = {63'd0, operand_a != operand_b};
         wai_pkg::OP_LTS:    front_in.res = {63'd0, lts};
         wai_pkg::OP_LTU:    front_in.res = {63'd0, ltu};
         wai_pkg::OP_GTS:    front_in.res = {63'd0, !lts && operand_a != operand_b};
         wai_pkg::OP_GTU:    front_in.res = {63'd0, !ltu && operand_a != operand_b};
         wai_pkg::OP_LES:    front_in.res = {63'd0, lts || operand_a == operand_b};
         wai_pkg::OP_LEU:    front_in.res = {63'd0, ltu || operand_a == operand_b};
         wai_pkg::OP_GES:    front_in.res = {63'd0, !lts};
         wai_pkg::OP_GEU:    front_in.res = {63'd0, !ltu};
         wai_pkg::OP_ROTL32: front_in.res = {32'd0, rot32l};
         wai_pkg::OP_ROTR32: front_in.res = {32'd0, rot32r};
         wai_pkg::OP_ROTL64: front_in.res = rot64l;
         wai_pkg::OP_ROTR64: front_in.res = rot64r;
         wai_pkg::OP_MUL: begin
            // product is built one multiplier bit per cell
            front_in.res = 64'd0;
            front_in.is_mul = 1'b1;
            front_in.quo = operand_b;
            front_in.dvs = operand_a;
         end
         wai_pkg::OP_SHL:    front_in.res = operand_a << s6;
         wai_pkg::OP_SHRS:   front_in.res = 64'($signed(operand_a) >>> s6);
         wai_pkg::OP_SHRU:   front_in.res = operand_a >> s6;
         wai_pkg::OP_DIVS, wai_pkg::OP_DIVU, wai_pkg::OP_REMS, wai_pkg::OP_REMU: begin
            front_in.res = 64'd0;
            if (operand_b == 64'd0) begin
               front_in.trap = wai_pkg::TRAP_DIV0;
            end else if (action == wai_pkg::OP_DIVS && operand_a == {1'b1, 63'd0}
                         && operand_b == '1) begin
               front_in.trap = wai_pkg::TRAP_OVF;
            end else begin
               front_in.is_div = 1'b1;
               front_in.want_rem = action == wai_pkg::OP_REMS || action == wai_pkg::OP_REMU;
               if (action == wai_pkg::OP_DIVS || action == wai_pkg::OP_REMS) begin
                  front_in.neg_q = an ^ bn;
                  front_in.neg_r = an;
               end else begin
                  front_in.dvs = operand_b;
                  front_in.quo = operand_a;
               end
            end
         end
         default: front_in.res = 64'd0;
      endcase
      // unused by a32 path; keeps width intent for 32-bit ops explicit
      if (action == wai_pkg::OP_POP32 && a32 == 64'd0) front_in.res = 64'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff.valid <= 1'b0;
      end else if (advance) begin
         front_ff <= front_in;
      end
   end

   assign cell_out = front_ff;
endmodule
`default_nettype wire

[sv/wasm_integer_alu_top.sv]
// Pipeline: a request passes through the entry register, the 64 cells and the output
// register, in that order. Throughput: one request per cycle; the whole chain
// advances together, held only while the output register is full and stalled.
// The 64-cell chain, one divide or multiply bit per cell, sets the latency.
// Reset (synchronous, active high) clears every valid bit in the chain.
`default_nettype none
module wasm_integer_alu_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [4:0]  req_action,
   input  wire logic [63:0] req_operand_a,
   input  wire logic [63:0] req_operand_b,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_result,
   output logic [1:0]       rsp_trap
);
   // one cell per operand bit
   localparam int unsigned NUM_CELLS = wai_pkg::NUM_CELLS_DEF;

   wai_pkg::cell_type chain [NUM_CELLS+1];
   wai_pkg::cell_type last;
   logic advance;
   logic out_valid_ff;
   logic [63:0] out_result_ff;
   logic [1:0]  out_trap_ff;
   logic [63:0] fin;

   assign advance = !(out_valid_ff && rsp_stall);
   assign req_stall = !advance;

   wai_front u_front (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(req_valid),
      .action(req_action), .operand_a(req_operand_a), .operand_b(req_operand_b),
      .cell_out(chain[0])
   );

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      wai_cell u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .cell_in(chain[g]), .cell_out(chain[g+1])
      );
   end

   assign last = chain[NUM_CELLS];

   always_comb begin
      fin = last.res;
      if (last.is_mul) begin
         fin = last.rem;
      end else if (last.is_div) begin
         if (last.want_rem) begin
            fin = last.neg_r ? (~last.rem + 64'd1) : last.rem;
         end else begin
            fin = last.neg_q ? (~last.quo + 64'd1) : last.quo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= last.valid;
         out_result_ff <= fin;
         out_trap_ff <= last.trap;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_result = out_result_ff;
   assign rsp_trap = out_trap_ff;

`include "wasm_integer_alu_top_assert.svh"
   `ALU_ASSERT_IMP(a_stall_only_when_full, req_stall, rsp_valid && rsp_stall)
   `ALU_ASSERT_IMP(a_trap_legal, rsp_valid, rsp_trap != 2'd3)
   `ALU_ASSERT_NEXT(a_hold_on_stall, rsp_valid && rsp_stall,
                    rsp_valid && $stable(rsp_result) && $stable(rsp_trap))
endmodule
`default_nettype wire
